### src/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int ID_BITS = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL = 3'd2,
		ST_REMOVED = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		op_t operation;
		logic [ID_BITS-1:0] process_id;
		logic [PRIORITY_BITS-1:0] priority_req;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [ID_BITS-1:0] removed_id;
		logic [PRIORITY_BITS-1:0] removed_priority;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic re;
		logic [ADDR_W-1:0] raddr;
		logic we;
		logic [ADDR_W-1:0] waddr;
		entry_t wdata;
	} mem_req_t;

endpackage

### src/spq_store.sv
module spq_store (
	input logic clk,
	input spq_pkg::mem_req_t mem_req,
	output spq_pkg::entry_t rd_data
);
	import spq_pkg::*;

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data <= mem[mem_req.raddr];
		end
	end

endmodule

### src/spq_seq.sv
module spq_seq (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input spq_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output spq_pkg::rsp_t rsp,
	output spq_pkg::mem_req_t mem_req,
	input spq_pkg::entry_t rd_data
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_PLACE,
		S_DONE
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [ID_BITS-1:0] id_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] cmp_idx_q;
	logic [CNT_W-1:0] pos_q;
	logic hit_q;
	logic [CNT_W-1:0] hit_idx_q;
	entry_t hit_ent_q;
	logic [CNT_W-1:0] w_q;
	status_t status_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [CNT_W-1:0] rd_sel;
	logic [CNT_W-1:0] wr_sel;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		rd_sel = '0;
		wr_sel = '0;
		mem_req.re = 1'b0;
		mem_req.we = 1'b0;
		mem_req.wdata = '{id: id_q, prio: prio_q};
		case (state_q)
			S_IDLE: begin
				mem_req.re = 1'b1;
			end
			S_SCAN: begin
				mem_req.re = 1'b1;
				rd_sel = cmp_idx_q + CNT_W'(1);
			end
			S_DECIDE: begin
				mem_req.re = 1'b1;
				if (op_q == OP_INSERT) begin
					rd_sel = held_q - CNT_W'(1);
				end else begin
					rd_sel = hit_idx_q + CNT_W'(1);
				end
			end
			S_SHIFT: begin
				mem_req.re = 1'b1;
				mem_req.we = 1'b1;
				wr_sel = w_q;
				mem_req.wdata = rd_data;
				if (op_q == OP_INSERT) begin
					rd_sel = w_q - CNT_W'(2);
				end else begin
					rd_sel = w_q + CNT_W'(2);
				end
			end
			S_PLACE: begin
				mem_req.we = 1'b1;
				wr_sel = pos_q;
			end
			default: begin
			end
		endcase
		mem_req.raddr = rd_sel[ADDR_W-1:0];
		mem_req.waddr = wr_sel[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q <= '0;
			rsp_valid_q <= 1'b0;
			op_q <= OP_INSERT;
			id_q <= '0;
			prio_q <= '0;
			cmp_idx_q <= '0;
			pos_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			hit_ent_q <= '0;
			w_q <= '0;
			status_q <= ST_INSERTED;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.operation;
						id_q <= req.process_id;
						prio_q <= req.priority_req;
						cmp_idx_q <= '0;
						pos_q <= '0;
						hit_q <= 1'b0;
						state_q <= (held_q == '0) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_data.prio > prio_q) begin
						pos_q <= pos_q + CNT_W'(1);
					end
					if (rd_data.id == id_q) begin
						hit_q <= 1'b1;
						hit_idx_q <= cmp_idx_q;
						hit_ent_q <= rd_data;
					end
					if (cmp_idx_q == held_q - CNT_W'(1)) begin
						state_q <= S_DECIDE;
					end else begin
						cmp_idx_q <= cmp_idx_q + CNT_W'(1);
					end
				end
				S_DECIDE: begin
					if (op_q == OP_INSERT) begin
						if (hit_q) begin
							status_q <= ST_DUPLICATE;
							state_q <= S_DONE;
						end else if (held_q == CNT_W'(CAPACITY)) begin
							status_q <= ST_FULL;
							state_q <= S_DONE;
						end else if (pos_q == held_q) begin
							state_q <= S_PLACE;
						end else begin
							w_q <= held_q;
							state_q <= S_SHIFT;
						end
					end else begin
						if (!hit_q) begin
							status_q <= ST_NOT_FOUND;
							state_q <= S_DONE;
						end else if (hit_idx_q == held_q - CNT_W'(1)) begin
							held_q <= held_q - CNT_W'(1);
							status_q <= ST_REMOVED;
							state_q <= S_DONE;
						end else begin
							w_q <= hit_idx_q;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (op_q == OP_INSERT) begin
						if (w_q - CNT_W'(1) == pos_q) begin
							state_q <= S_PLACE;
						end else begin
							w_q <= w_q - CNT_W'(1);
						end
					end else begin
						if (w_q + CNT_W'(2) == held_q) begin
							held_q <= held_q - CNT_W'(1);
							status_q <= ST_REMOVED;
							state_q <= S_DONE;
						end else begin
							w_q <= w_q + CNT_W'(1);
						end
					end
				end
				S_PLACE: begin
					held_q <= held_q + CNT_W'(1);
					status_q <= ST_INSERTED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status <= status_q;
						rsp_q.removed_id <= (status_q == ST_REMOVED) ? hit_ent_q.id : '0;
						rsp_q.removed_priority <=
							(status_q == ST_REMOVED) ? hit_ent_q.prio : '0;
						rsp_q.entry_count <= held_q;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/sorted_priority_queue.sv
// Every request scans the entries held (at most 16); a duplicate, full or not-found result ends
// there, while an insert or remove may go on to shift entries to keep the queue sorted.
// One request at a time: the entry memory's single read and write port sets the pace.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) empties the queue; entry memory is not cleared.
module sorted_priority_queue (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input spq_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	mem_req_t mem_req;
	entry_t rd_data;

	spq_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	spq_store u_store (
		.clk(clk),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

endmodule

### src/spq_checker.sv
module spq_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result dropped or changed while stalled");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_REMOVED |->
			rsp.removed_id == '0 && rsp.removed_priority == '0)
		else $error("removed fields set on a result without a removal");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(CAPACITY))
		else $error("full reported with free space");

	a_removed_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_REMOVED |-> rsp.entry_count < CNT_W'(CAPACITY))
		else $error("removal left a full queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

### dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 1826;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef enum int unsigned {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	class sched_queue_tracker;
		entry_t slots[CAPACITY];
		int held;
		int peak_held;
		rsp_t awaited[$];
		int unsigned status_seen[5];
		int unsigned requests;
		int unsigned mismatches;

		function new();
			held = 0;
			peak_held = 0;
			requests = 0;
			mismatches = 0;
			foreach (status_seen[k])
				status_seen[k] = 0;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function logic [ID_BITS-1:0] pick_held_id();
			return slots[$urandom_range(0, held - 1)].id;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int hit;
			int pos;
			int k;
			e = '0;
			hit = -1;
			for (k = 0; k < held; k++)
				if (slots[k].id == r.process_id)
					hit = k;
			if (r.operation == OP_INSERT) begin
				if (hit >= 0) begin
					e.status = ST_DUPLICATE;
				end else if (held == CAPACITY) begin
					e.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < held && slots[pos].prio > r.priority_req)
						pos++;
					for (k = held; k > pos; k--)
						slots[k] = slots[k - 1];
					slots[pos].id = r.process_id;
					slots[pos].prio = r.priority_req;
					held++;
					e.status = ST_INSERTED;
				end
			end else if (hit < 0) begin
				e.status = ST_NOT_FOUND;
			end else begin
				e.status = ST_REMOVED;
				e.removed_id = slots[hit].id;
				e.removed_priority = slots[hit].prio;
				for (k = hit; k + 1 < held; k++)
					slots[k] = slots[k + 1];
				held--;
			end
			e.entry_count = CNT_W'(held);
			if (held > peak_held)
				peak_held = held;
			awaited.push_back(e);
			status_seen[int'(e.status)]++;
			requests++;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				report($sformatf("response %p with no request outstanding", got));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.removed_id !== want.removed_id)
				report($sformatf("removed_id %h, want %h", got.removed_id, want.removed_id));
			if (got.removed_priority !== want.removed_priority)
				report($sformatf("removed_priority %h, want %h",
					got.removed_priority, want.removed_priority));
			if (got.entry_count !== want.entry_count)
				report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	sched_queue_tracker tracker = new();
	int unsigned cycles = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int unsigned rx_left = 0;
	logic [7:0] rx_pattern = 8'h01;

	sorted_priority_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d responses outstanding",
				cycles, tracker.outstanding());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(50, 400);
			rx_pattern <= 8'($urandom) | 8'h01;
		end else begin
			rx_left <= rx_left - 1;
			if (rx_mode == RX_PATTERN)
				rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
		end
		case (rx_mode)
			RX_ALWAYS: rsp_ready <= 1'b1;
			RX_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
			default: rsp_ready <= rx_pattern[0];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
	end

	function automatic req_t make_req(op_t op, logic [ID_BITS-1:0] id,
			logic [PRIORITY_BITS-1:0] prio);
		req_t r;
		r.operation = op;
		r.process_id = id;
		r.priority_req = prio;
		return r;
	endfunction

	function automatic logic [PRIORITY_BITS-1:0] pick_priority();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'h8000;
			3: return 16'h0001;
			default: return PRIORITY_BITS'($urandom);
		endcase
	endfunction

	function automatic req_t random_request(bit filling);
		req_t r;
		r.priority_req = pick_priority();
		if ($urandom_range(0, 99) < (filling ? 80 : 25)) begin
			r.operation = OP_INSERT;
			if (tracker.held > 0 && $urandom_range(0, 9) == 0)
				r.process_id = tracker.pick_held_id();
			else
				r.process_id = ID_BITS'($urandom);
		end else begin
			r.operation = OP_REMOVE;
			if (tracker.held > 0 && $urandom_range(0, 9) < 8)
				r.process_id = tracker.pick_held_id();
			else
				r.process_id = ID_BITS'($urandom);
		end
		return r;
	endfunction

	task automatic send_request(req_t r);
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_request(r);
	endtask

	task automatic idle_gap(int unsigned n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_directed();
		int unsigned k;
		send_request(make_req(OP_REMOVE, 16'h0005, 16'hFFFF));
		send_request(make_req(OP_INSERT, 16'h0000, 16'h0000));
		send_request(make_req(OP_INSERT, 16'hFFFF, 16'hFFFF));
		send_request(make_req(OP_INSERT, 16'h0000, 16'h1234));
		// equal priorities go ahead of older entries
		for (k = 0; k < 14; k++)
			send_request(make_req(OP_INSERT, ID_BITS'(16'h0100 + k),
				k[0] ? 16'h8000 : 16'h0000));
		send_request(make_req(OP_INSERT, 16'hABCD, 16'h5555));
		send_request(make_req(OP_INSERT, 16'h0100, 16'hAAAA));
		send_request(make_req(OP_REMOVE, 16'hFFFF, 16'h0000));
		send_request(make_req(OP_REMOVE, 16'h0000, 16'hFFFF));
		send_request(make_req(OP_REMOVE, 16'h0107, 16'h1234));
		send_request(make_req(OP_REMOVE, 16'h0000, 16'h0000));
	endtask

	task automatic run_random(int unsigned total);
		int unsigned sent;
		int unsigned burst;
		int unsigned k;
		bit filling;
		sent = 0;
		filling = 1'b1;
		while (sent < total) begin
			burst = $urandom_range(1, 24);
			for (k = 0; k < burst && sent < total; k++) begin
				send_request(random_request(filling));
				sent++;
				if (filling && tracker.held == CAPACITY && $urandom_range(0, 7) == 0)
					filling = 1'b0;
				else if (!filling && tracker.held == 0 && $urandom_range(0, 3) == 0)
					filling = 1'b1;
			end
			if ($urandom_range(0, 11) == 0)
				wait_drained();
			else if ($urandom_range(0, 2) != 0)
				idle_gap($urandom_range(1, 8));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		run_random(RANDOM_REQUESTS);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests, queue depth peaked at %0d of %0d",
			tracker.requests, tracker.peak_held, CAPACITY);
		$display("Outcomes: %0d inserted, %0d duplicate, %0d full, %0d removed, %0d not found",
			tracker.status_seen[ST_INSERTED], tracker.status_seen[ST_DUPLICATE],
			tracker.status_seen[ST_FULL], tracker.status_seen[ST_REMOVED],
			tracker.status_seen[ST_NOT_FOUND]);
		if (tracker.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
